### rtl/gac_pkg.sv
// ---------------------------------------------------------------------------
// gac_pkg
// Shared types, codes and helpers for the glyph alpha compositor.
// ---------------------------------------------------------------------------
package gac_pkg;

    // Opcodes of an input beat
    localparam logic [2:0] OP_BEGIN  = 3'd0;
    localparam logic [2:0] OP_HEADER = 3'd1;
    localparam logic [2:0] OP_COVER  = 3'd2;
    localparam logic [2:0] OP_END    = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [9:0] FRAME_WIDTH_RESET  = 10'd512;
    localparam logic [7:0] FRAME_HEIGHT_RESET = 8'd128;

    localparam logic [11:0] RECT_MAX = 12'hFFF;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [11:0]        img_width;
        logic [11:0]        img_height;
        logic [31:0]        color;
        logic [7:0]         coverage;
        logic [15:0]        read_addr;
    } item_beat_t;

    typedef struct packed {
        logic               kind;
        logic               drawn;
        logic signed [11:0] rect_x;
        logic signed [11:0] rect_y;
        logic [11:0]        rect_w;
        logic [11:0]        rect_h;
        logic [31:0]        pixel_value;
    } result_beat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_ADDR,
        ST_PIX_READ,
        ST_PIX_MUL,
        ST_PIX_WRITE,
        ST_RD_DATA,
        ST_PUSH
    } gac_state_t;

    // Rounded division by 255: (v + 127) / 255, valid for v below 65153
    function automatic logic [7:0] div255r(input logic [16:0] v);
        logic [17:0] t;
        logic [17:0] q;
        t = 18'(v) + 18'd127;
        q = (t + (t >> 8) + 18'd1) >> 8;
        return q[7:0];
    endfunction

endpackage

### rtl/glyph_alpha_compositor.sv
// ---------------------------------------------------------------------------
// glyph_alpha_compositor
// Source-over compositor of colored coverage masks into an ARGB8888 store.
// ---------------------------------------------------------------------------
// The frame store is one synchronous single-write/single-read RAM of
// MAX_WIDTH*MAX_HEIGHT words. After reset the store is swept to zero, one
// word per cycle; a begin beat starts the same sweep. No item is taken
// during the sweep, while config writes are. A coverage beat that hits the
// frame goes through address multiply, RAM read, channel products, divide
// and write back; one that is clipped stops after the address step, one of
// zero alpha after the alpha check. An end beat goes straight to the push
// state and a read beat through the RAM read (straight there when off the
// frame) to reach the output register, waiting while a stalled result
// still holds that register. The read-modify-write of one pixel through the
// single RAM port pair sets the pixel rate. A finished result waits in the
// output register while the next item is taken.
module glyph_alpha_compositor
    import gac_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 128
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  item_beat_t   item,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [9:0]   cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WCAP  = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
    localparam int HCAP  = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;

    // Frame store
    logic [31:0]   mem [DEPTH];
    logic [31:0]   mem_q;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata;

    gac_state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [9:0] fw_reg, fw_next;
    logic [7:0] fh_reg, fh_next;
    logic signed [11:0] org_x_reg, org_x_next, org_y_reg, org_y_next;
    logic [11:0] size_w_reg, size_w_next, size_h_reg, size_h_next;
    logic [31:0] rgba_reg, rgba_next;
    logic [11:0] col_reg, col_next, row_reg, row_next;
    logic signed [13:0] min_x_reg, min_x_next, min_y_reg, min_y_next;
    logic signed [13:0] max_x_reg, max_x_next, max_y_reg, max_y_next;
    logic content_reg, content_next;
    logic signed [13:0] fx_reg, fx_next, fy_reg, fy_next;
    logic [7:0] cov_reg, cov_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [7:0] sa_reg, sa_next;
    logic [16:0] pa_reg, pa_next, pr_reg, pr_next, pg_reg, pg_next, pb_reg, pb_next;
    result_beat_t pend_reg, pend_next, out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    // Active frame size
    logic [9:0]  act_w;
    logic [7:0]  act_h;
    logic [17:0] lim;
    assign act_w = (fw_reg < 10'(WCAP)) ? fw_reg : 10'(WCAP);
    assign act_h = (fh_reg < 8'(HCAP)) ? fh_reg : 8'(HCAP);
    assign lim   = 18'(act_w) * 18'(act_h);

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Scratch values for the next-state logic
    logic signed [13:0] px, py, ex, ey;
    logic signed [14:0] dx, dy;
    logic [11:0] rw, rh;
    logic [12:0] col_inc;
    logic in_frame;
    logic [17:0] idx_calc;
    logic [AW+17:0] idx_wide;
    logic [AW+15:0] rd_wide;
    logic [7:0] a_src, inv, oa, orr, og, ob;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        org_x_next     = org_x_reg;
        org_y_next     = org_y_reg;
        size_w_next    = size_w_reg;
        size_h_next    = size_h_reg;
        rgba_next      = rgba_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        min_x_next     = min_x_reg;
        min_y_next     = min_y_reg;
        max_x_next     = max_x_reg;
        max_y_next     = max_y_reg;
        content_next   = content_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        cov_next       = cov_reg;
        idx_next       = idx_reg;
        sa_next        = sa_reg;
        pa_next        = pa_reg;
        pr_next        = pr_reg;
        pg_next        = pg_reg;
        pb_next        = pb_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = idx_reg;
        mem_raddr      = idx_reg;
        mem_wdata      = '0;

        px = {{2{item.pos_x[11]}}, item.pos_x};
        py = {{2{item.pos_y[11]}}, item.pos_y};
        ex = px + $signed({2'b00, item.img_width});
        ey = py + $signed({2'b00, item.img_height});
        dx = 15'(max_x_reg) - 15'(min_x_reg);
        dy = 15'(max_y_reg) - 15'(min_y_reg);
        rw = (max_x_reg <= min_x_reg) ? 12'd0 : (dx > 15'sd4095) ? RECT_MAX : dx[11:0];
        rh = (max_y_reg <= min_y_reg) ? 12'd0 : (dy > 15'sd4095) ? RECT_MAX : dy[11:0];
        col_inc  = 13'(col_reg) + 13'd1;
        in_frame = !fx_reg[13] && !fy_reg[13] && (fx_reg < $signed({4'b0, act_w}))
                   && (fy_reg < $signed({6'b0, act_h}));
        idx_calc = 18'(fy_reg[7:0]) * 18'(act_w) + 18'(fx_reg[9:0]);
        idx_wide = {{AW{1'b0}}, idx_calc};
        rd_wide  = {{AW{1'b0}}, item.read_addr};
        a_src    = ~rgba_reg[7:0];
        inv      = ~sa_reg;
        oa       = sa_reg + div255r(pa_reg);
        orr      = div255r(pr_reg);
        og       = div255r(pg_reg);
        ob       = div255r(pb_reg);

        // Config writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_next = cfg_data;
                REG_FRAME_HEIGHT: fh_next = cfg_data[7:0];
                default: ;
            endcase
        end

        // Output register drains
        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.opcode)
                        OP_BEGIN:
                        begin
                            org_x_next   = '0;
                            org_y_next   = '0;
                            size_w_next  = '0;
                            size_h_next  = '0;
                            rgba_next    = '0;
                            col_next     = '0;
                            row_next     = '0;
                            content_next = 1'b0;
                            min_x_next   = $signed({4'b0, act_w});
                            min_y_next   = $signed({6'b0, act_h});
                            max_x_next   = '0;
                            max_y_next   = '0;
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        OP_HEADER:
                        begin
                            org_x_next  = item.pos_x;
                            org_y_next  = item.pos_y;
                            size_w_next = item.img_width;
                            size_h_next = item.img_height;
                            rgba_next   = item.color;
                            col_next    = '0;
                            row_next    = '0;
                            if (item.img_width != 12'd0 && item.img_height != 12'd0)
                            begin
                                content_next = 1'b1;
                                if (px < min_x_reg) min_x_next = px;
                                if (py < min_y_reg) min_y_next = py;
                                if (ex > max_x_reg) max_x_next = ex;
                                if (ey > max_y_reg) max_y_next = ey;
                            end
                        end
                        OP_COVER:
                        begin
                            if (size_w_reg != 12'd0 && size_h_reg != 12'd0
                                && row_reg < size_h_reg)
                            begin
                                fx_next  = {{2{org_x_reg[11]}}, org_x_reg}
                                           + $signed({2'b00, col_reg});
                                fy_next  = {{2{org_y_reg[11]}}, org_y_reg}
                                           + $signed({2'b00, row_reg});
                                cov_next = item.coverage;
                                if (col_inc >= 13'(size_w_reg))
                                begin
                                    col_next = '0;
                                    row_next = row_reg + 12'd1;
                                end
                                else
                                    col_next = col_inc[11:0];
                                state_next = ST_PIX_ADDR;
                            end
                        end
                        OP_END:
                        begin
                            pend_next = '0;
                            pend_next.kind = KIND_SUMMARY;
                            pend_next.drawn = content_reg;
                            if (content_reg)
                            begin
                                pend_next.rect_x = min_x_reg[11:0];
                                pend_next.rect_y = min_y_reg[11:0];
                                pend_next.rect_w = rw;
                                pend_next.rect_h = rh;
                            end
                            state_next = ST_PUSH;
                        end
                        OP_READ:
                        begin
                            pend_next = '0;
                            pend_next.kind = KIND_PIXEL;
                            if (18'(item.read_addr) < lim)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = rd_wide[AW-1:0];
                                state_next = ST_RD_DATA;
                            end
                            else
                                state_next = ST_PUSH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PIX_ADDR:
            begin
                sa_next    = div255r(17'(16'(cov_reg) * 16'(a_src)));
                idx_next   = idx_wide[AW-1:0];
                state_next = in_frame ? ST_PIX_READ : ST_IDLE;
            end
            ST_PIX_READ:
            begin
                if (sa_reg == 8'd0)
                    state_next = ST_IDLE;
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_PIX_MUL;
                end
            end
            ST_PIX_MUL:
            begin
                pa_next = 17'(16'(mem_q[31:24]) * 16'(inv));
                pr_next = 17'(16'(rgba_reg[31:24]) * 16'(sa_reg))
                          + 17'(16'(mem_q[23:16]) * 16'(inv));
                pg_next = 17'(16'(rgba_reg[23:16]) * 16'(sa_reg))
                          + 17'(16'(mem_q[15:8]) * 16'(inv));
                pb_next = 17'(16'(rgba_reg[15:8]) * 16'(sa_reg))
                          + 17'(16'(mem_q[7:0]) * 16'(inv));
                state_next = ST_PIX_WRITE;
            end
            ST_PIX_WRITE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {oa, orr, og, ob};
                state_next = ST_IDLE;
            end
            ST_RD_DATA:
            begin
                pend_next.pixel_value = mem_q;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            fw_reg        <= FRAME_WIDTH_RESET;
            fh_reg        <= FRAME_HEIGHT_RESET;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            size_w_reg    <= '0;
            size_h_reg    <= '0;
            rgba_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            min_x_reg     <= $signed({4'b0, FRAME_WIDTH_RESET});
            min_y_reg     <= $signed({6'b0, FRAME_HEIGHT_RESET});
            max_x_reg     <= '0;
            max_y_reg     <= '0;
            content_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            org_x_reg     <= org_x_next;
            org_y_reg     <= org_y_next;
            size_w_reg    <= size_w_next;
            size_h_reg    <= size_h_next;
            rgba_reg      <= rgba_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            min_x_reg     <= min_x_next;
            min_y_reg     <= min_y_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
            content_reg   <= content_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        cov_reg  <= cov_next;
        idx_reg  <= idx_next;
        sa_reg   <= sa_next;
        pa_reg   <= pa_next;
        pr_reg   <= pr_next;
        pg_reg   <= pg_next;
        pb_reg   <= pb_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // Frame store RAM, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= mem[mem_raddr];
    end

endmodule

### rtl/gac_checker.sv
// ---------------------------------------------------------------------------
// gac_props
// Port-level checks for the glyph alpha compositor, bound to the top level.
// ---------------------------------------------------------------------------
module gac_props
    import gac_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         item_valid,
    input logic         item_ready,
    input item_beat_t   item,
    input logic         result_valid,
    input logic         result_ready,
    input result_beat_t result
);

    // No result beat while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // A stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // Pixel beats carry no rectangle
    a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_PIXEL |->
            !result.drawn && result.rect_x == 12'd0 && result.rect_y == 12'd0
            && result.rect_w == 12'd0 && result.rect_h == 12'd0)
        else $error("pixel beat with rectangle fields");

    // Empty summary has zero width, height, x origin and pixel value
    a_empty_summary: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_SUMMARY && !result.drawn |->
            result.rect_w == 12'd0 && result.rect_h == 12'd0
            && result.rect_x == 12'd0 && result.pixel_value == 32'd0)
        else $error("empty summary not zero");

    // Begin starts the store sweep, so input stalls
    a_begin_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.opcode == OP_BEGIN |=> !item_ready)
        else $error("item taken right after begin");

endmodule

bind glyph_alpha_compositor gac_props u_gac_props (.*);

### dv/gac_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gac_checker
// Watches the item, result and config ports of the glyph alpha compositor,
// keeps its own copy of the frame store and dirty tracking, works out the
// result each accepted item should give and compares it with what comes out.
// ---------------------------------------------------------------------------
module gac_checker
    import gac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         item_ready,
    input  item_beat_t   item,
    input  logic         result_valid,
    input  logic         result_ready,
    input  result_beat_t result,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [9:0]   cfg_data,
    output int           errors,
    output int           pending,
    output int           results_seen
);

    localparam int MAX_W = 512;
    localparam int MAX_H = 128;

    // Predicted state
    logic [31:0]  pixels [0:65535];
    logic [9:0]   fw;
    logic [7:0]   fh;
    int           org_x, org_y, sz_w, sz_h, col, row;
    logic [31:0]  rgba;
    int           min_x, min_y, max_x, max_y;
    logic         drew;
    result_beat_t awaited [$];

    function automatic int act_w();
        return (fw < MAX_W) ? int'(fw) : MAX_W;
    endfunction

    function automatic int act_h();
        return (fh < MAX_H) ? int'(fh) : MAX_H;
    endfunction

    function automatic int rdiv(input int v);
        return (v + 127) / 255;
    endfunction

    task automatic wipe_frame();
        for (int i = 0; i < 65536; i++)
            pixels[i] = '0;
        org_x = 0; org_y = 0; sz_w = 0; sz_h = 0; col = 0; row = 0;
        rgba  = '0;
        drew  = 1'b0;
        max_x = 0; max_y = 0;
    endtask

    // Source-over of one coverage value at the current image position
    task automatic blend_at(input int cov);
        int fx, fy, sa, inv, idx;
        logic [31:0] d;
        logic [7:0] oa, orr, og, ob;
        fx = org_x + col;
        fy = org_y + row;
        if (fx < 0 || fy < 0 || fx >= act_w() || fy >= act_h())
            return;
        sa = rdiv(cov * (255 - int'(rgba[7:0])));
        if (sa == 0)
            return;
        idx = fy * act_w() + fx;
        d   = pixels[idx];
        inv = 255 - sa;
        oa  = 8'(sa + rdiv(int'(d[31:24]) * inv));
        orr = 8'(rdiv(int'(rgba[31:24]) * sa + int'(d[23:16]) * inv));
        og  = 8'(rdiv(int'(rgba[23:16]) * sa + int'(d[15:8]) * inv));
        ob  = 8'(rdiv(int'(rgba[15:8]) * sa + int'(d[7:0]) * inv));
        pixels[idx] = {oa, orr, og, ob};
    endtask

    task automatic apply_item(input item_beat_t it);
        result_beat_t r;
        int rw, rh, lim;
        r = '0;
        case (it.opcode)
            OP_BEGIN:
            begin
                wipe_frame();
                min_x = act_w();
                min_y = act_h();
            end
            OP_HEADER:
            begin
                org_x = int'(it.pos_x);
                org_y = int'(it.pos_y);
                sz_w  = int'(it.img_width);
                sz_h  = int'(it.img_height);
                rgba  = it.color;
                col   = 0;
                row   = 0;
                if (sz_w != 0 && sz_h != 0)
                begin
                    drew = 1'b1;
                    if (org_x < min_x) min_x = org_x;
                    if (org_y < min_y) min_y = org_y;
                    if (org_x + sz_w > max_x) max_x = org_x + sz_w;
                    if (org_y + sz_h > max_y) max_y = org_y + sz_h;
                end
            end
            OP_COVER:
            begin
                if (sz_w != 0 && sz_h != 0 && row < sz_h)
                begin
                    blend_at(int'(it.coverage));
                    col++;
                    if (col >= sz_w)
                    begin
                        col = 0;
                        row++;
                    end
                end
            end
            OP_END:
            begin
                r.kind  = KIND_SUMMARY;
                r.drawn = drew;
                if (drew)
                begin
                    rw = (max_x > min_x) ? max_x - min_x : 0;
                    rh = (max_y > min_y) ? max_y - min_y : 0;
                    if (rw > 4095) rw = 4095;
                    if (rh > 4095) rh = 4095;
                    r.rect_x = 12'(min_x);
                    r.rect_y = 12'(min_y);
                    r.rect_w = 12'(rw);
                    r.rect_h = 12'(rh);
                end
                awaited.push_back(r);
            end
            OP_READ:
            begin
                lim           = act_w() * act_h();
                r.kind        = KIND_PIXEL;
                r.pixel_value = (int'(it.read_addr) < lim) ? pixels[it.read_addr] : '0;
                awaited.push_back(r);
            end
            default:
            begin
                // unused opcodes: no effect
            end
        endcase
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    task automatic compare_beat(input result_beat_t got);
        result_beat_t w;
        if (awaited.size() == 0)
        begin
            report("unexpected result beat", got.pixel_value, 32'd0);
            return;
        end
        w = awaited.pop_front();
        if (got.kind != w.kind)
            report("kind", 32'(got.kind), 32'(w.kind));
        if (got.drawn != w.drawn)
            report("drawn", 32'(got.drawn), 32'(w.drawn));
        if (got.rect_x != w.rect_x)
            report("rect_x", 32'(got.rect_x), 32'(w.rect_x));
        if (got.rect_y != w.rect_y)
            report("rect_y", 32'(got.rect_y), 32'(w.rect_y));
        if (got.rect_w != w.rect_w)
            report("rect_w", 32'(got.rect_w), 32'(w.rect_w));
        if (got.rect_h != w.rect_h)
            report("rect_h", 32'(got.rect_h), 32'(w.rect_h));
        if (got.pixel_value != w.pixel_value)
            report("pixel_value", got.pixel_value, w.pixel_value);
    endtask

    initial
    begin
        errors       = 0;
        pending      = 0;
        results_seen = 0;
        fw           = FRAME_WIDTH_RESET;
        fh           = FRAME_HEIGHT_RESET;
        wipe_frame();
        min_x = act_w();
        min_y = act_h();
    end

    // Results are compared before this edge's item is applied
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                compare_beat(result);
                results_seen++;
            end
            if (item_valid && item_ready)
                apply_item(item);
        end
        if (cfg_we)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
                fw = cfg_data;
            else
                fh = cfg_data[7:0];
        end
        pending = awaited.size();
    end

endmodule

### dv/tb_glyph_alpha_compositor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_glyph_alpha_compositor
// Drives begin, header, coverage, end and read beats into the compositor
// under several frame sizes and idle patterns; the checker predicts and
// compares every result, this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_glyph_alpha_compositor;
    import gac_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 20;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    item_beat_t   item;
    logic         result_valid;
    logic         result_ready;
    result_beat_t result;
    logic         cfg_we;
    logic         cfg_index;
    logic [9:0]   cfg_data;

    int errors, pending, results_seen;
    int idle_mode;      // 0 none, 1 sender, 2 receiver, 3 both
    int beats_sent;
    int cfg_writes;
    int quiet_cycles;
    int aw, ah;         // frame size in use, for stimulus shaping

    glyph_alpha_compositor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    gac_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver stalls
    always @(posedge clk)
    begin
        if (idle_mode == 2)
            result_ready <= ($urandom_range(0, 99) >= 56);
        else if (idle_mode == 3)
            result_ready <= ($urandom_range(0, 99) >= 21);
        else
            result_ready <= 1'b1;
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("FAIL");
            $finish;
        end
    end

    function automatic item_beat_t noise_beat();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(item_beat_t)-1:0];
    endfunction

    // One beat, held until accepted
    task automatic send(input item_beat_t it);
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == 3) ? 21 : 56;
        if (idle_mode == 1 || idle_mode == 3)
            while ($urandom_range(0, 99) < pct)
                gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(item_valid && item_ready));
        beats_sent++;
    endtask

    task automatic send_op(input logic [2:0] op);
        item_beat_t it;
        it        = noise_beat();
        it.opcode = op;
        send(it);
    endtask

    task automatic send_header(input int x, input int y, input int w, input int h,
                               input logic [31:0] c);
        item_beat_t it;
        it            = noise_beat();
        it.opcode     = OP_HEADER;
        it.pos_x      = 12'(x);
        it.pos_y      = 12'(y);
        it.img_width  = 12'(w);
        it.img_height = 12'(h);
        it.color      = c;
        send(it);
    endtask

    task automatic send_cov(input int cv);
        item_beat_t it;
        it          = noise_beat();
        it.opcode   = OP_COVER;
        it.coverage = 8'(cv);
        send(it);
    endtask

    task automatic send_read(input int a);
        item_beat_t it;
        it           = noise_beat();
        it.opcode    = OP_READ;
        it.read_addr = 16'(a);
        send(it);
    endtask

    // Drain all results and let any trailing pixel work finish
    task automatic settle();
        item_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input int v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 10'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        cfg_writes++;
        if (idx == REG_FRAME_WIDTH)
            aw = (v < 512) ? v : 512;
        else
            ah = (v < 128) ? v : 128;
    endtask

    function automatic int rand_cov();
        int p;
        p = $urandom_range(0, 99);
        if (p < 30) return 255;
        if (p < 50) return 0;
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [31:0] rand_color();
        logic [31:0] c;
        int p;
        c = $urandom;
        p = $urandom_range(0, 9);
        if (p < 3) c[7:0] = 8'h00;
        else if (p == 3) c[7:0] = 8'hFF;
        return c;
    endfunction

    // One image: header then its coverage, sometimes cut short or overrun
    task automatic draw_image();
        int w, h, n;
        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        send_header(int'($urandom_range(0, aw + 8)) - 6, int'($urandom_range(0, ah + 6)) - 4,
                    w, h, rand_color());
        n = w * h;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(0, n);
        else
            n = n + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        if (n == 0)
            n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            send_cov(rand_cov());
    endtask

    task automatic random_phase(input int n_items);
        int start, p;
        start = beats_sent;
        send_op(OP_BEGIN);
        while (beats_sent - start < n_items)
        begin
            p = $urandom_range(0, 99);
            if (p < 55)
                draw_image();
            else if (p < 85)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_read($urandom_range(0, 65535));
                else
                    send_read($urandom_range(0, aw * ah - 1));
            end
            else if (p < 93)
                send_op(OP_END);
            else if (p < 96)
                send_header(int'($urandom_range(0, 4095)) - 2048,
                            int'($urandom_range(0, 4095)) - 2048,
                            $urandom_range(0, 2048), $urandom_range(0, 2048), $urandom);
            else
                send_op(3'($urandom_range(5, 7)));
        end
        send_op(OP_END);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b1;
        cfg_we       = 1'b0;
        cfg_index    = REG_FRAME_WIDTH;
        cfg_data     = '0;
        idle_mode    = 0;
        beats_sent   = 0;
        cfg_writes   = 0;
        quiet_cycles = 0;
        aw           = 512;
        ah           = 128;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset values, extremes and the special cases
        send_read(0);
        send_read(65535);
        send_op(OP_END);                          // nothing drawn
        send_header(5, 5, 0, 3, 32'h11223300);    // zero-sized image
        send_cov(255);
        send_op(OP_END);
        send_header(-2048, -2048, 2048, 2048, 32'h0);
        send_header(2047, 2047, 2048, 1, 32'h0);  // saturating rectangle
        send_op(OP_END);
        send_op(OP_BEGIN);
        send_header(510, 126, 3, 3, 32'hFF800000); // clipped at right and bottom
        for (int i = 0; i < 9; i++)
            send_cov((i % 3 == 1) ? 128 : 255 - i);
        send_cov(77);                             // surplus
        send_header(508, 0, 2, 1, 32'h12345680);  // blend over partial alpha
        send_cov(200);
        send_cov(1);                              // rounds to zero alpha
        send_header(510, 126, 1, 1, 32'hABCDEFFF); // fully transparent
        send_cov(255);
        send_read(126 * 512 + 510);
        send_read(126 * 512 + 511);
        send_read(508);
        send_op(3'd5);
        send_op(3'd6);
        send_op(3'd7);
        send_op(OP_END);

        // Random phases, one frame size and idle pattern each
        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            idle_mode = ph;
            case (ph)
                0: begin cfg_write(REG_FRAME_WIDTH, 1023); cfg_write(REG_FRAME_HEIGHT, 255); end
                1: begin cfg_write(REG_FRAME_WIDTH, 24);   cfg_write(REG_FRAME_HEIGHT, 12);  end
                2: begin cfg_write(REG_FRAME_WIDTH, 1);    cfg_write(REG_FRAME_HEIGHT, 128); end
                default: begin cfg_write(REG_FRAME_WIDTH, 40); cfg_write(REG_FRAME_HEIGHT, 1); end
            endcase
            random_phase(170);
        end

        item_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("covered %0d item beats, %0d results, %0d register writes",
                 beats_sent, results_seen, cfg_writes);
        $display("frame sizes from 1x128 to 1023x255 under four idle patterns");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
